// ===== rtl/rgbconv_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// RGB 3x3 convolution filter: shared types and constants
// Field layouts of the request and response beats, the job that travels from
// the front end to the arithmetic back end, and the register map.
// ----------------------------------------------------------------------------
package rgbconv_pkg;

   localparam int MaxWidth     = 1024;
   localparam int ColW         = $clog2(MaxWidth);
   localparam int WidthW       = 11;
   localparam int HeightW      = 16;
   localparam int ChanW        = 8;
   localparam int PixW         = 3 * ChanW;
   localparam int TapW         = 20;
   localparam int CoefRowW     = 3 * TapW;
   localparam int CoefFracBits = 16;

   localparam int ProdW = TapW + ChanW + 1;
   localparam int PsumW = ProdW + 2;
   localparam int SumW  = ProdW + 4;

   localparam int QDepth = 4;
   localparam int QPtrW  = $clog2(QDepth);
   localparam int QCntW  = $clog2(QDepth + 1);

   localparam int CsrIdxW  = 3;
   localparam int CsrDataW = CoefRowW;

   localparam logic [CsrIdxW-1:0] CSR_IMAGE_WIDTH  = 3'd0;
   localparam logic [CsrIdxW-1:0] CSR_IMAGE_HEIGHT = 3'd1;
   localparam logic [CsrIdxW-1:0] CSR_COEF_TOP     = 3'd2;
   localparam logic [CsrIdxW-1:0] CSR_COEF_MID     = 3'd3;
   localparam logic [CsrIdxW-1:0] CSR_COEF_BOTTOM  = 3'd4;

   localparam logic CMD_PIXEL = 1'b0;
   localparam logic CMD_FLUSH = 1'b1;

   localparam logic [WidthW-1:0]   WidthReset   = 11'd1024;
   localparam logic [HeightW-1:0]  HeightReset  = 16'd768;
   localparam logic [CoefRowW-1:0] CoefMidReset = 60'h10_0000_0000;

   localparam logic [ChanW-1:0] ChanMax = 8'd255;

   typedef struct packed {
      logic             cmd;
      logic [ChanW-1:0] in_red;
      logic [ChanW-1:0] in_green;
      logic [ChanW-1:0] in_blue;
   } req_data_type;

   typedef struct packed {
      logic [ChanW-1:0] out_red;
      logic [ChanW-1:0] out_green;
      logic [ChanW-1:0] out_blue;
      logic             last_of_step;
      logic             frame_done;
   } rsp_data_type;

   typedef struct packed {
      logic [CoefRowW-1:0] top;
      logic [CoefRowW-1:0] mid;
      logic [CoefRowW-1:0] bottom;
   } coef_set_type;

   // One result: centre column of the window (1 or 2) and edge substitution
   typedef struct packed {
      logic cc_right;
      logic left_ok;
      logic right_ok;
      logic frame_done;
   } res_desc_type;

   typedef struct packed {
      logic [8:0][PixW-1:0] pix;
      logic                 top_ok;
      logic                 bot_ok;
      logic                 two;
      res_desc_type         res0;
      res_desc_type         res1;
   } job_type;

   typedef struct packed {
      logic             not_empty;
      logic [QCntW-1:0] count;
   } q_status_type;

   typedef struct packed {
      logic [PixW-1:0] above;
      logic [PixW-1:0] current;
   } line_pair_type;

endpackage
`default_nettype wire

// ===== rtl/rgb_3x3_convolution_filter_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// RGB 3x3 convolution filter unit
// Streams RGB pixels in raster order and applies one shared 3x3 kernel to each channel.
//
// Request channel (req_*): one beat per pixel (cmd pixel) or per flush.
// A beat is taken on a clock edge with req_valid high and req_stall low.
// Response channel (rsp_*): filtered pixels in raster order, one row behind
// the input; last_of_step marks the final result of a request beat and
// frame_done the last pixel of the frame. After the last pixel of a frame,
// send one flush beat per pixel of the bottom row to drain it.
// Configuration (csr_*): plain write port, taken on any edge with csr_wr_en
// high; write only while the unit is idle. Width or height writes restart
// the frame.
// Throughput: one request beat per cycle while req_stall is low; a beat at
// the end of a row yields two results and the response side moves one per
// cycle while rsp_stall is low, the four-entry job queue absorbs the
// difference. A beat reaches its first result through the line buffer read,
// the job queue, three arithmetic stages and the output register.
// Reset is synchronous; it restores identity coefficients, 1024x768 geometry
// and empties all pipelines. A stalled response holds; the queue keeps taking
// requests until the queued jobs plus the beat in the second stage reach the queue depth, then req_stall rises.
// ----------------------------------------------------------------------------
module rgb_3x3_convolution_filter_unit (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_valid,
   output logic                             req_stall,
   input  rgbconv_pkg::req_data_type        req_data,
   output logic                             rsp_valid,
   input  wire                              rsp_stall,
   output rgbconv_pkg::rsp_data_type        rsp_data,
   input  wire                              csr_wr_en,
   input  wire [rgbconv_pkg::CsrIdxW-1:0]   csr_index,
   input  wire [rgbconv_pkg::CsrDataW-1:0]  csr_wr_data
);
   import rgbconv_pkg::*;

   q_status_type q_status;
   logic         q_push, q_pop;
   job_type      q_job, q_head;
   coef_set_type coefs;

   rgbconv_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .q_status    (q_status),
      .q_push      (q_push),
      .q_job       (q_job),
      .coefs       (coefs)
   );

   rgbconv_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (q_job),
      .pop      (q_pop),
      .head     (q_head),
      .status   (q_status)
   );

   rgbconv_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_status  (q_status),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .coefs     (coefs),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire

// ===== rtl/rgbconv_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// RGB 3x3 convolution filter: front end
// Takes request beats, tracks input and output raster positions, keeps the
// line buffer and the 3x3 window, and hands one job per productive beat to
// the job queue.
// ----------------------------------------------------------------------------
module rgbconv_front (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_valid,
   output logic                             req_stall,
   input  rgbconv_pkg::req_data_type        req_data,
   input  wire                              csr_wr_en,
   input  wire [rgbconv_pkg::CsrIdxW-1:0]   csr_index,
   input  wire [rgbconv_pkg::CsrDataW-1:0]  csr_wr_data,
   input  rgbconv_pkg::q_status_type        q_status,
   output logic                             q_push,
   output rgbconv_pkg::job_type             q_job,
   output rgbconv_pkg::coef_set_type        coefs
);
   import rgbconv_pkg::*;

   typedef struct packed {
      logic [HeightW-1:0] row;
      logic [ColW-1:0]    col;
   } pos_type;

   typedef struct packed {
      logic            flush;
      logic            has_res;
      logic            col_zero;
      logic [ColW-1:0] addr;
      logic [PixW-1:0] px;
      logic            top_ok;
      logic            bot_ok;
      logic            two;
      res_desc_type    res0;
      res_desc_type    res1;
   } s1_type;

   function automatic pos_type pos_step(pos_type p, logic [ColW:0] w);
      pos_type n;
      if (({1'b0, p.col} + 1'b1) >= w) begin
         n.col = '0;
         n.row = p.row + 1'b1;
      end else begin
         n.col = p.col + 1'b1;
         n.row = p.row;
      end
      return n;
   endfunction

   function automatic logic pos_last(pos_type p, logic [ColW:0] w,
                                     logic [HeightW-1:0] h);
      return (({1'b0, p.row} + 1'b1) >= {1'b0, h}) && (({1'b0, p.col} + 1'b1) >= w);
   endfunction

   logic [WidthW-1:0]  width_ff;
   logic [HeightW-1:0] height_ff;
   coef_set_type       coef_ff;
   pos_type            in_pos_ff, in_pos_in;
   pos_type            out_pos_ff, out_pos_in;
   logic [ColW:0]      eff_w;
   logic [HeightW-1:0] eff_h;

   logic               accept, pix_ok, fl_ok, in_done, last_col, row_nz, emit_a, emit_b;
   logic [ColW:0]      c_ext;
   pos_type            p0, p1, p2;
   logic               fd0, fd1;
   s1_type             s1_in, s1_ff;
   logic               s1_valid_ff;

   logic [ColW-1:0]      mem_raddr;
   logic                 mem_re, mem_we;
   line_pair_type        mem_wdata;
   line_pair_type        rd_ff;
   line_pair_type        line_mem [MaxWidth];

   logic [8:0][PixW-1:0] win_ff, win_in;
   line_pair_type [2:0]  fw_ff, fw_in;
   line_pair_type        col0_ff, col0_in;

   always_comb begin
      if (width_ff == '0) begin
         eff_w = (ColW+1)'(1);
      end else if (32'(width_ff) > MaxWidth) begin
         eff_w = (ColW+1)'(MaxWidth);
      end else begin
         eff_w = (ColW+1)'(width_ff);
      end
      eff_h = (height_ff == '0) ? HeightW'(1) : height_ff;
   end

   assign coefs     = coef_ff;
   assign accept    = req_valid && !req_stall;
   assign req_stall = (int'(q_status.count) + int'(s1_valid_ff)) >= QDepth;

   // Classify the beat and work out the next positions
   always_comb begin
      p0       = out_pos_ff;
      p1       = pos_step(p0, eff_w);
      p2       = pos_step(p1, eff_w);
      fd0      = pos_last(p0, eff_w, eff_h);
      fd1      = pos_last(p1, eff_w, eff_h);
      c_ext    = {1'b0, in_pos_ff.col};
      last_col = (c_ext + 1'b1) >= eff_w;
      in_done  = in_pos_ff.row >= eff_h;
      pix_ok   = (req_data.cmd == CMD_PIXEL) && !in_done && (c_ext < eff_w);
      fl_ok    = (req_data.cmd == CMD_FLUSH) && in_done && ({1'b0, out_pos_ff.col} < eff_w);
      row_nz   = in_pos_ff.row != '0;
      emit_a   = row_nz && (in_pos_ff.col != '0);
      emit_b   = row_nz && last_col;

      s1_in      = '0;
      s1_in.px   = {req_data.in_red, req_data.in_green, req_data.in_blue};
      in_pos_in  = in_pos_ff;
      out_pos_in = out_pos_ff;
      mem_raddr  = in_pos_ff.col;

      if (pix_ok) begin
         s1_in.flush    = 1'b0;
         s1_in.has_res  = emit_a || emit_b;
         s1_in.col_zero = in_pos_ff.col == '0;
         s1_in.addr     = in_pos_ff.col;
         s1_in.top_ok   = in_pos_ff.row >= HeightW'(2);
         s1_in.bot_ok   = 1'b1;
         s1_in.two      = emit_a && emit_b;
         if (emit_a) begin
            s1_in.res0 = '{cc_right: 1'b0, left_ok: (in_pos_ff.col >= ColW'(2)),
                           right_ok: 1'b1, frame_done: fd0};
         end else begin
            s1_in.res0 = '{cc_right: 1'b1, left_ok: (in_pos_ff.col != '0),
                           right_ok: 1'b0, frame_done: fd0};
         end
         s1_in.res1 = '{cc_right: 1'b1, left_ok: 1'b1, right_ok: 1'b0, frame_done: fd1};
         if (emit_a && emit_b) begin
            out_pos_in = p2;
         end else if (emit_a || emit_b) begin
            out_pos_in = p1;
         end
         if (last_col) begin
            in_pos_in.col = '0;
            in_pos_in.row = in_pos_ff.row + 1'b1;
         end else begin
            in_pos_in.col = in_pos_ff.col + 1'b1;
         end
      end else if (fl_ok) begin
         mem_raddr      = out_pos_ff.col + 1'b1;
         s1_in.flush    = 1'b1;
         s1_in.has_res  = 1'b1;
         s1_in.col_zero = out_pos_ff.col == '0;
         s1_in.addr     = out_pos_ff.col + 1'b1;
         s1_in.top_ok   = out_pos_ff.row != '0;
         s1_in.bot_ok   = 1'b0;
         s1_in.two      = 1'b0;
         s1_in.res0     = '{cc_right: 1'b0, left_ok: (out_pos_ff.col != '0),
                            right_ok: (({1'b0, out_pos_ff.col} + 1'b1) < eff_w),
                            frame_done: fd0};
         s1_in.res1     = s1_in.res0;
         if (fd0) begin
            in_pos_in  = '0;
            out_pos_in = '0;
         end else begin
            out_pos_in = p1;
         end
      end
   end

   assign mem_re = accept && (pix_ok || fl_ok);

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff    <= WidthReset;
         height_ff   <= HeightReset;
         coef_ff     <= '{top: '0, mid: CoefMidReset, bottom: '0};
         in_pos_ff   <= '0;
         out_pos_ff  <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= mem_re;
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_IMAGE_WIDTH: begin
                  width_ff   <= csr_wr_data[WidthW-1:0];
                  in_pos_ff  <= '0;
                  out_pos_ff <= '0;
               end
               CSR_IMAGE_HEIGHT: begin
                  height_ff  <= csr_wr_data[HeightW-1:0];
                  in_pos_ff  <= '0;
                  out_pos_ff <= '0;
               end
               CSR_COEF_TOP:    coef_ff.top    <= csr_wr_data[CoefRowW-1:0];
               CSR_COEF_MID:    coef_ff.mid    <= csr_wr_data[CoefRowW-1:0];
               CSR_COEF_BOTTOM: coef_ff.bottom <= csr_wr_data[CoefRowW-1:0];
               default: ;
            endcase
         end else if (mem_re) begin
            in_pos_ff  <= in_pos_in;
            out_pos_ff <= out_pos_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mem_re) begin
         s1_ff <= s1_in;
      end
   end

   // Second stage: shift the window, write the line buffer back, build the job
   always_comb begin
      win_in    = win_ff;
      fw_in     = fw_ff;
      col0_in   = col0_ff;
      mem_we    = 1'b0;
      mem_wdata = '{above: rd_ff.current, current: s1_ff.px};
      q_job     = '0;
      if (s1_valid_ff && !s1_ff.flush) begin
         for (int r = 0; r < 3; r++) begin
            win_in[r*3]   = win_ff[r*3+1];
            win_in[r*3+1] = win_ff[r*3+2];
         end
         win_in[2] = rd_ff.above;
         win_in[5] = rd_ff.current;
         win_in[8] = s1_ff.px;
         mem_we    = 1'b1;
         if (s1_ff.col_zero) begin
            col0_in = mem_wdata;
         end
      end
      if (s1_valid_ff && s1_ff.flush) begin
         if (s1_ff.col_zero) begin
            fw_in = {rd_ff, col0_ff, fw_ff[1]};
         end else begin
            fw_in = {rd_ff, fw_ff[2], fw_ff[1]};
         end
      end
      if (s1_ff.flush) begin
         for (int dc = 0; dc < 3; dc++) begin
            q_job.pix[dc]   = fw_in[dc].above;
            q_job.pix[3+dc] = fw_in[dc].current;
            q_job.pix[6+dc] = fw_in[dc].current;
         end
      end else begin
         q_job.pix = win_in;
      end
      q_job.top_ok = s1_ff.top_ok;
      q_job.bot_ok = s1_ff.bot_ok;
      q_job.two    = s1_ff.two;
      q_job.res0   = s1_ff.res0;
      q_job.res1   = s1_ff.res1;
   end

   assign q_push = s1_valid_ff && s1_ff.has_res;

   always_ff @(posedge clock) begin
      win_ff  <= win_in;
      fw_ff   <= fw_in;
      col0_ff <= col0_in;
   end

   // Line buffer: write-first so a beat right behind sees the fresh entry
   always_ff @(posedge clock) begin
      if (mem_we) begin
         line_mem[s1_ff.addr] <= mem_wdata;
      end
      if (mem_re) begin
         if (mem_we && (s1_ff.addr == mem_raddr)) begin
            rd_ff <= mem_wdata;
         end else begin
            rd_ff <= line_mem[mem_raddr];
         end
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      ({1'b0, out_pos_ff.col} < eff_w) && ({1'b0, in_pos_ff.col} < eff_w))
      else $error("raster column beyond image width");

endmodule
`default_nettype wire

// ===== rtl/rgbconv_fifo.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// RGB 3x3 convolution filter: job queue
// Short queue of jobs between the front end and the arithmetic back end.
// ----------------------------------------------------------------------------
module rgbconv_fifo (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        push,
   input  rgbconv_pkg::job_type       push_job,
   input  wire                        pop,
   output rgbconv_pkg::job_type       head,
   output rgbconv_pkg::q_status_type  status
);
   import rgbconv_pkg::*;

   job_type           slot_ff [QDepth];
   logic [QPtrW-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [QCntW-1:0]  count_ff;

   function automatic logic [QPtrW-1:0] ptr_next(logic [QPtrW-1:0] p);
      return (p == QPtrW'(QDepth - 1)) ? '0 : p + 1'b1;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ptr_next(wr_ptr_ff);
         end
         if (pop) begin
            rd_ptr_ff <= ptr_next(rd_ptr_ff);
         end
         count_ff <= count_ff + QCntW'(push) - QCntW'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

   assign head             = slot_ff[rd_ptr_ff];
   assign status.not_empty = count_ff != '0;
   assign status.count     = count_ff;

   assert property (@(posedge clock) disable iff (reset) push |-> (count_ff < QCntW'(QDepth)))
      else $error("job queue overflow");

   assert property (@(posedge clock) disable iff (reset) pop |-> (count_ff != '0))
      else $error("job queue underflow");

endmodule
`default_nettype wire

// ===== rtl/rgbconv_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// RGB 3x3 convolution filter: arithmetic back end
// Expands each job into one or two results, substitutes edge taps with the
// centre pixel, multiplies, sums, floors and clamps per channel.
// ----------------------------------------------------------------------------
module rgbconv_back (
   input  wire                        clock,
   input  wire                        reset,
   input  rgbconv_pkg::q_status_type  q_status,
   input  rgbconv_pkg::job_type       q_head,
   output logic                       q_pop,
   input  rgbconv_pkg::coef_set_type  coefs,
   output logic                       rsp_valid,
   input  wire                        rsp_stall,
   output rgbconv_pkg::rsp_data_type  rsp_data
);
   import rgbconv_pkg::*;

   function automatic logic signed [TapW-1:0] tap_of(coef_set_type cs, int r, int dc);
      logic [CoefRowW-1:0] row;
      case (r)
         0:       row = cs.top;
         1:       row = cs.mid;
         default: row = cs.bottom;
      endcase
      return $signed(row[dc*TapW +: TapW]);
   endfunction

   function automatic logic [ChanW-1:0] clamp_chan(logic signed [SumW-1:0] s);
      if (s <= 0) begin
         return '0;
      end else if (|s[SumW-1:CoefFracBits+ChanW]) begin
         return ChanMax;
      end else begin
         return s[CoefFracBits+ChanW-1:CoefFracBits];
      end
   endfunction

   logic                 sub_ff;
   logic                 take, out_ready, b0_ready, b1_ready, b2_ready;
   res_desc_type         res;
   logic                 last;
   logic [PixW-1:0]      centre;
   logic [8:0][PixW-1:0] nb_in;

   logic                 b0_valid_ff, b1_valid_ff, b2_valid_ff, rsp_valid_ff;
   logic [8:0][PixW-1:0] b0_nb_ff;
   logic                 b0_last_ff, b1_last_ff, b2_last_ff;
   logic                 b0_fd_ff, b1_fd_ff, b2_fd_ff;
   logic signed [ProdW-1:0] b1_prod_in [3][9];
   logic signed [ProdW-1:0] b1_prod_ff [3][9];
   logic signed [PsumW-1:0] b2_psum_in [3][3];
   logic signed [PsumW-1:0] b2_psum_ff [3][3];
   logic signed [SumW-1:0]  sum [3];
   rsp_data_type            rsp_data_ff, rsp_in;

   assign out_ready = !rsp_valid_ff || !rsp_stall;
   assign b2_ready  = !b2_valid_ff || out_ready;
   assign b1_ready  = !b1_valid_ff || b2_ready;
   assign b0_ready  = !b0_valid_ff || b1_ready;
   assign take      = q_status.not_empty && b0_ready;
   assign q_pop     = take && (!q_head.two || sub_ff);

   // Pick the result of this beat and substitute taps outside the image
   always_comb begin
      int  col;
      logic ok;
      res    = sub_ff ? q_head.res1 : q_head.res0;
      last   = !q_head.two || sub_ff;
      centre = res.cc_right ? q_head.pix[5] : q_head.pix[4];
      for (int dr = 0; dr < 3; dr++) begin
         for (int dc = 0; dc < 3; dc++) begin
            ok  = (dr != 0 || q_head.top_ok) && (dr != 2 || q_head.bot_ok) &&
                  (dc != 0 || res.left_ok) && (dc != 2 || res.right_ok);
            col = dc + (res.cc_right ? 1 : 0);
            if (col > 2) begin
               col = 2;
            end
            nb_in[dr*3+dc] = ok ? q_head.pix[dr*3+col] : centre;
         end
      end
   end

   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         for (int r = 0; r < 3; r++) begin
            for (int dc = 0; dc < 3; dc++) begin
               b1_prod_in[ch][r*3+dc] = ProdW'(tap_of(coefs, r, dc)) *
                  ProdW'($signed({1'b0, b0_nb_ff[r*3+dc][PixW-1-ChanW*ch -: ChanW]}));
            end
         end
         for (int g = 0; g < 3; g++) begin
            b2_psum_in[ch][g] = PsumW'(b1_prod_ff[ch][3*g]) + PsumW'(b1_prod_ff[ch][3*g+1]) +
                                PsumW'(b1_prod_ff[ch][3*g+2]);
         end
         sum[ch] = SumW'(b2_psum_ff[ch][0]) + SumW'(b2_psum_ff[ch][1]) +
                   SumW'(b2_psum_ff[ch][2]);
      end
      rsp_in.out_red      = clamp_chan(sum[0]);
      rsp_in.out_green    = clamp_chan(sum[1]);
      rsp_in.out_blue     = clamp_chan(sum[2]);
      rsp_in.last_of_step = b2_last_ff;
      rsp_in.frame_done   = b2_fd_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sub_ff       <= 1'b0;
         b0_valid_ff  <= 1'b0;
         b1_valid_ff  <= 1'b0;
         b2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (take) begin
            sub_ff <= q_head.two && !sub_ff;
         end
         if (b0_ready) begin
            b0_valid_ff <= take;
         end
         if (b1_ready) begin
            b1_valid_ff <= b0_valid_ff;
         end
         if (b2_ready) begin
            b2_valid_ff <= b1_valid_ff;
         end
         if (out_ready) begin
            rsp_valid_ff <= b2_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         b0_nb_ff   <= nb_in;
         b0_last_ff <= last;
         b0_fd_ff   <= res.frame_done;
      end
      if (b1_ready && b0_valid_ff) begin
         b1_prod_ff <= b1_prod_in;
         b1_last_ff <= b0_last_ff;
         b1_fd_ff   <= b0_fd_ff;
      end
      if (b2_ready && b1_valid_ff) begin
         b2_psum_ff <= b2_psum_in;
         b2_last_ff <= b1_last_ff;
         b2_fd_ff   <= b1_fd_ff;
      end
      if (out_ready && b2_valid_ff) begin
         rsp_data_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assert property (@(posedge clock) disable iff (reset)
      sub_ff |-> (q_status.not_empty && q_head.two))
      else $error("second result pending without a two-result job at the head");

endmodule
`default_nettype wire
